>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

>>> sv/agrs_pkg.sv
// ---------------------------------------------------------------------------
// Anchor gap run splitter package
// Field widths, queue sizing and the command passed from front to back.
// ---------------------------------------------------------------------------
package agrs_pkg;

  // Field widths of the stream items.
  localparam int RankW     = 32;
  localparam int NodeLenW  = 32;
  localparam int RunLenW   = 33;
  localparam int CfgW      = 48;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 72;

  // Command queue between front and back.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Results caused by one step: an optional closed run, then an optional
  // end-of-path result. Lengths are worked out from start and end in the back.
  typedef struct packed {
    logic             has_close;
    logic [RankW-1:0] close_start;
    logic [RankW-1:0] close_end;
    logic             has_final;
    logic             final_err;
    logic [RankW-1:0] final_start;
    logic [RankW-1:0] final_end;
  } cmd_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

>>> sv/agrs_front.sv
// ---------------------------------------------------------------------------
// Anchor gap run splitter front
// Accepts steps, tracks the open run and the gap sum, and issues commands.
// ---------------------------------------------------------------------------
module agrs_front #(
  parameter int RANK_BITS = 32,
  parameter int GAP_BITS  = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [agrs_pkg::RankW-1:0]  rank_in,
  input  logic                        is_anchor,
  input  logic [agrs_pkg::NodeLenW-1:0] node_length,
  input  logic                        last_step,
  input  logic                        cfg_we,
  input  logic [agrs_pkg::CfgW-1:0]   cfg_data,
  output logic                        push,
  output agrs_pkg::cmd_t              cmd
);
  import agrs_pkg::*;

  localparam int CmpW = (GAP_BITS > NodeLenW) ? GAP_BITS : NodeLenW;
  localparam logic [RankW-1:0] RankMask =
    (RANK_BITS >= RankW) ? {RankW{1'b1}} : RankW'((64'd1 << RANK_BITS) - 64'd1);

  logic [GAP_BITS-1:0] max_gap;
  logic                anchor_seen, anchor_seen_next;
  logic                gap_over, gap_over_next;
  logic [RankW-1:0]    open_run_start, open_run_start_next;
  logic [RankW-1:0]    latest_anchor, latest_anchor_next;
  logic [GAP_BITS-1:0] gap_sum, gap_sum_next;

  logic [RankW-1:0]    rank;
  logic [CmpW-1:0]     max_x, sum_x, len_x;
  logic                exceeds;

  assign rank  = rank_in & RankMask;
  assign max_x = CmpW'(max_gap);
  assign sum_x = CmpW'(gap_sum);
  assign len_x = CmpW'(node_length);

  // The limit is passed once the sum already sits above it, or the step's
  // length does not fit in the room left.
  assign exceeds = (sum_x > max_x) || (len_x > (max_x - sum_x));

  // Next state and the results this step causes.
  always_comb begin
    anchor_seen_next    = anchor_seen;
    gap_over_next       = gap_over;
    open_run_start_next = open_run_start;
    latest_anchor_next  = latest_anchor;
    gap_sum_next        = gap_sum;

    cmd.has_close   = is_anchor && anchor_seen && gap_over;
    cmd.close_start = open_run_start;
    cmd.close_end   = latest_anchor;

    if (is_anchor) begin
      if (!anchor_seen || gap_over) begin
        open_run_start_next = rank;
      end
      anchor_seen_next   = 1'b1;
      latest_anchor_next = rank;
      gap_sum_next       = '0;
      gap_over_next      = 1'b0;
    end else if (anchor_seen && !gap_over) begin
      if (exceeds) begin
        gap_over_next = 1'b1;
      end else begin
        gap_sum_next = GAP_BITS'(sum_x + len_x);
      end
    end

    // End of path: report the open run or the missing anchor.
    cmd.has_final   = last_step;
    cmd.final_err   = !anchor_seen_next;
    cmd.final_start = anchor_seen_next ? open_run_start_next : '0;
    cmd.final_end   = anchor_seen_next ? latest_anchor_next : '0;

    if (last_step) begin
      anchor_seen_next    = 1'b0;
      gap_over_next       = 1'b0;
      open_run_start_next = '0;
      latest_anchor_next  = '0;
      gap_sum_next        = '0;
    end
  end

  assign push = accept && (cmd.has_close || cmd.has_final);

  // Run state and the gap limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap        <= '0;
      anchor_seen    <= 1'b0;
      gap_over       <= 1'b0;
      open_run_start <= '0;
      latest_anchor  <= '0;
      gap_sum        <= '0;
    end else begin
      if (cfg_we) begin
        max_gap <= GAP_BITS'({{GAP_BITS{1'b0}}, cfg_data});
      end
      if (accept) begin
        anchor_seen    <= anchor_seen_next;
        gap_over       <= gap_over_next;
        open_run_start <= open_run_start_next;
        latest_anchor  <= latest_anchor_next;
        gap_sum        <= gap_sum_next;
      end
    end
  end

endmodule

>>> sv/agrs_queue.sv
// ---------------------------------------------------------------------------
// Anchor gap run splitter command queue
// Small register FIFO that decouples the front from the back.
// ---------------------------------------------------------------------------
module agrs_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  agrs_pkg::cmd_t           push_cmd,
  input  logic                     pop,
  output agrs_pkg::cmd_t           head,
  output agrs_pkg::queue_status_t  status
);
  import agrs_pkg::*;

  cmd_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_pop;

  assign status.full      = (count == QueueCntW'(QueueDepth));
  assign status.not_empty = (count != '0);
  assign head             = entries[rd_ptr];
  assign do_pop           = pop && status.not_empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> sv/agrs_back.sv
// ---------------------------------------------------------------------------
// Anchor gap run splitter back
// Turns queued commands into result items in an output register.
// ---------------------------------------------------------------------------
module agrs_back #(
  parameter int RANK_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  agrs_pkg::cmd_t                head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [agrs_pkg::RankW-1:0]    out_start,
  output logic [agrs_pkg::RunLenW-1:0]  out_len,
  output logic                          out_err,
  output logic                          out_last
);
  import agrs_pkg::*;

  // Rank differences are taken modulo 2^RANK_BITS; beyond the result width
  // only the low bits matter.
  localparam int DiffW = (RANK_BITS < RunLenW) ? RANK_BITS : RunLenW;

  logic               phase;
  logic               load;
  logic               take_close;
  logic [RankW-1:0]   sel_start, sel_end;
  logic [DiffW-1:0]   diff;
  logic [RunLenW-1:0] run_len;

  assign load       = !out_valid || out_ready;
  assign take_close = !phase && head.has_close;
  assign pop        = load && q_valid && !(take_close && head.has_final);

  assign sel_start = take_close ? head.close_start : head.final_start;
  assign sel_end   = take_close ? head.close_end : head.final_end;
  assign diff      = DiffW'(sel_end) - DiffW'(sel_start);
  assign run_len   = RunLenW'(RunLenW'(diff) + RunLenW'(1));

  // Output valid and the position within a two-result command.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        phase <= take_close && head.has_final;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_start <= sel_start;
      if (take_close) begin
        out_len  <= run_len;
        out_err  <= 1'b0;
        out_last <= 1'b0;
      end else begin
        out_len  <= head.final_err ? '0 : run_len;
        out_err  <= head.final_err;
        out_last <= 1'b1;
      end
    end
  end

endmodule

>>> sv/anchor_gap_run_splitter.sv
// ---------------------------------------------------------------------------
// Anchor gap run splitter
// Groups the anchor steps of a path into runs split at oversized gaps.
// ---------------------------------------------------------------------------
// Usage:
//   Steps enter on the s_ stream in rank order, one item per step. s_tlast
//   marks the final step of a path; s_tuser says whether the step is an
//   anchor. Results leave on the m_ stream; m_tlast marks the final result
//   of a path and m_tuser flags a path that had no anchor (start and length
//   are then zero). The gap limit is written on the cfg channel, which is
//   always ready, and should only change while the block is idle.
//   Throughput is one step per cycle while the command queue has room.
//   A step yields zero, one or two results; a step with two results holds
//   the output for both of them. The front updates the run state and
//   enqueues a command at the accepting edge, and the back loads the output
//   register from the queue head once that register is free.
//   Reset clears the run state, the gap limit and the four-entry command
//   queue. When the receiver stalls the queue fills, and s_tready drops once
//   it holds four commands.
// ---------------------------------------------------------------------------
module anchor_gap_run_splitter #(
  parameter int RANK_BITS = 32,
  parameter int GAP_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  // Step stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [agrs_pkg::InDataW-1:0]  s_tdata,  // rank[31:0], node_length[63:32]
  input  logic                          s_tuser,  // is_anchor
  input  logic                          s_tlast,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [agrs_pkg::OutDataW-1:0] m_tdata,  // start_rank[31:0], run_length[64:32], zeros
  output logic                          m_tuser,  // no_anchor_error
  output logic                          m_tlast,
  // Gap limit write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [agrs_pkg::CfgW-1:0]     cfg_data
);
  import agrs_pkg::*;

  `include "assert_macros.svh"

  logic                accept;
  logic                push;
  cmd_t                push_cmd;
  cmd_t                head;
  queue_status_t       q_status;
  logic                pop;
  logic [RankW-1:0]    out_start;
  logic [RunLenW-1:0]  out_len;

  assign s_tready  = !q_status.full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Front: run tracking.
  agrs_front #(
    .RANK_BITS(RANK_BITS),
    .GAP_BITS (GAP_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rank_in    (s_tdata[RankW-1:0]),
    .is_anchor  (s_tuser),
    .node_length(s_tdata[RankW+NodeLenW-1:RankW]),
    .last_step  (s_tlast),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Command queue.
  agrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // Back: result output.
  agrs_back #(
    .RANK_BITS(RANK_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_status.not_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_start(out_start),
    .out_len  (out_len),
    .out_err  (m_tuser),
    .out_last (m_tlast)
  );

  assign m_tdata = {{(OutDataW - RankW - RunLenW){1'b0}}, out_len, out_start};

  // The front only pushes when the queue has room.
  `ASSERT_NEVER(a_queue_no_overflow, clk, rst, push && q_status.full,
                "command pushed into a full queue")

  // A missing-anchor result ends its path and carries no run.
  `ASSERT_PROP(a_error_result_form, clk, rst,
               (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)),
               "malformed no-anchor result")

  // A queued command reaches the output as soon as the output is free.
  `ASSERT_PROP(a_back_drains_queue, clk, rst,
               (q_status.not_empty && (!m_tvalid || m_tready)) |=> m_tvalid,
               "back failed to take a queued command")

endmodule
